// ----- rtl/core/rcftc_pkg.sv -----
// Shared types and constants for the RC channel frame threshold checker.
package rcftc_pkg;

  // Frame layout
  localparam int unsigned CHAN_BITS       = 11;
  localparam int unsigned NUM_CHANNELS    = 16;
  localparam int unsigned CHAN_START_BYTE = 3;
  localparam int unsigned TYPE_BYTE       = 2;
  localparam int unsigned MIN_FRAME_LEN   =
    CHAN_START_BYTE + (NUM_CHANNELS * CHAN_BITS) / 8 + 1;

  // CRC-8, polynomial 0xD5, MSB first
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE  = 2'd2;

  localparam logic [4:0]  CHANNEL_SELECT_RST = 5'd1;
  localparam logic [10:0] THRESHOLD_RST      = 11'd1024;
  localparam logic [7:0]  EXPECTED_TYPE_RST  = 8'd22;

  // Result codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
  localparam logic [1:0] STATUS_BAD_CRC  = 2'd3;

  localparam logic [1:0] ACTION_NONE  = 2'd0;
  localparam logic [1:0] ACTION_START = 2'd1;
  localparam logic [1:0] ACTION_STOP  = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  action;
    logic [10:0] chan_level;
  } result_t;

  // One byte of CRC-8, eight shift steps unrolled
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rcftc_if.sv -----
// Valid/ready channel interfaces for frame bytes in and check results out.
interface rcftc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output mode, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input last_byte,
                  output ready);
endinterface

interface rcftc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  action;
  logic [10:0] chan_level;

  modport source (output valid, output status, output action, output chan_level,
                  input ready);
  modport sink   (input valid, input status, input action, input chan_level,
                  output ready);
endinterface

// ----- rtl/core/rc_channel_frame_threshold_checker_top.sv -----
// RC channel frame threshold checker: input register, frame logic, result register.
// A last byte's result passes through the input register, then the result register.
// Throughput: one transaction per cycle; the input stage stalls only when a result
// must be written while the result register is full and not being taken.
// Reset (synchronous, rst_n low): channel select 1, threshold 1024, expected type 22,
// frame state cleared, a threshold check pending, both channel stages empty.
module rc_channel_frame_threshold_checker_top #(
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rcftc_in_if.sink                             in_ch,
  rcftc_out_if.source                          out_ch,
  input  logic                                 cfg_wr_en,
  input  logic [rcftc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcftc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME_LEN + 1);

  // Configuration registers
  logic [4:0]  channel_select_r;
  logic [10:0] threshold_r;
  logic [7:0]  expected_type_r;

  // Input stage
  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        s1_has_result;
  logic        s1_adv;

  // Result stage
  logic                 out_valid_r;
  rcftc_pkg::result_t   out_data_r;
  rcftc_pkg::result_t   frame_result;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_select_r <= rcftc_pkg::CHANNEL_SELECT_RST;
      threshold_r      <= rcftc_pkg::THRESHOLD_RST;
      expected_type_r  <= rcftc_pkg::EXPECTED_TYPE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcftc_pkg::CFG_CHANNEL_SELECT: channel_select_r <= cfg_wdata[4:0];
        rcftc_pkg::CFG_THRESHOLD:      threshold_r      <= cfg_wdata[10:0];
        rcftc_pkg::CFG_EXPECTED_TYPE:  expected_type_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: only a last byte in byte mode needs room in the result register
  assign s1_has_result = s1_last_r && (s1_mode_r == rcftc_pkg::MODE_BYTE);
  assign s1_adv        = s1_valid_r && (!s1_has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode_r <= in_ch.mode;
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  rcftc_frame #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .IDX_W         (IDX_W)
  ) u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (s1_adv),
    .mode           (s1_mode_r),
    .data_byte      (s1_data_r),
    .last_byte      (s1_last_r),
    .channel_select (channel_select_r),
    .threshold      (threshold_r),
    .expected_type  (expected_type_r),
    .result         (frame_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      out_data_r <= frame_result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.action     = out_data_r.action;
  assign out_ch.chan_level = out_data_r.chan_level;

endmodule

// ----- rtl/core/rcftc_chan_capture.sv -----
// Picks the bits of the selected 11-bit channel out of one frame byte.
module rcftc_chan_capture #(
  parameter int unsigned IDX_W = 7
) (
  input  logic [IDX_W-1:0] byte_idx,
  input  logic [7:0]       data_byte,
  input  logic [4:0]       channel_select,
  input  logic [10:0]      bits_in,
  output logic [10:0]      bits_out
);

  logic [3:0]       chan_idx;
  logic [7:0]       lo_bit;
  logic             in_payload;
  logic [IDX_W-1:0] payload_idx;

  // Clamp the one-based select into 0..15
  always_comb begin
    if (channel_select == 5'd0) begin
      chan_idx = 4'd0;
    end else if (channel_select > 5'(rcftc_pkg::NUM_CHANNELS)) begin
      chan_idx = 4'(rcftc_pkg::NUM_CHANNELS - 1);
    end else begin
      chan_idx = 4'(channel_select - 5'd1);
    end
  end

  assign lo_bit      = 8'(chan_idx) * 8'(rcftc_pkg::CHAN_BITS);
  assign in_payload  = byte_idx >= IDX_W'(rcftc_pkg::CHAN_START_BYTE);
  assign payload_idx = byte_idx - IDX_W'(rcftc_pkg::CHAN_START_BYTE);

  // Each channel bit lives at one fixed bit of one payload byte
  always_comb begin
    logic [7:0] p;
    bits_out = bits_in;
    for (int k = 0; k < 11; k++) begin
      p = lo_bit + 8'(k);
      if (in_payload && (IDX_W'(p[7:3]) == payload_idx)) begin
        bits_out[k] = data_byte[p[2:0]];
      end
    end
  end

endmodule

// ----- rtl/core/rcftc_frame.sv -----
// Per-frame state: byte count, type, CRC, channel bits; builds the result at the last byte.
module rcftc_frame #(
  parameter int unsigned MAX_FRAME_LEN = 64,
  parameter int unsigned IDX_W         = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [4:0]          channel_select,
  input  logic [10:0]         threshold,
  input  logic [7:0]          expected_type,
  output rcftc_pkg::result_t  result
);

  logic [IDX_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_crc_r, running_crc_nxt;
  logic [7:0]       frame_type_r, frame_type_nxt;
  logic [10:0]      channel_bits_r, channel_bits_nxt;
  logic             check_due_r, check_due_nxt;
  logic             overlong_r, overlong_nxt;

  logic [10:0]      captured_bits;
  logic [IDX_W:0]   frame_len;
  logic             bad_len;
  logic             full;

  rcftc_chan_capture #(
    .IDX_W (IDX_W)
  ) u_capture (
    .byte_idx       (byte_count_r),
    .data_byte      (data_byte),
    .channel_select (channel_select),
    .bits_in        (channel_bits_r),
    .bits_out       (captured_bits)
  );

  assign full      = byte_count_r >= IDX_W'(MAX_FRAME_LEN);
  assign frame_len = {1'b0, byte_count_r} + (IDX_W+1)'(1);
  assign bad_len   = overlong_r
                  || (frame_len < (IDX_W+1)'(rcftc_pkg::MIN_FRAME_LEN))
                  || (frame_len > (IDX_W+1)'(MAX_FRAME_LEN));

  // Status in priority order, then the threshold compare on a good frame
  always_comb begin
    result = '0;
    if (bad_len) begin
      result.status = rcftc_pkg::STATUS_BAD_LEN;
    end else if (frame_type_r != expected_type) begin
      result.status = rcftc_pkg::STATUS_BAD_TYPE;
    end else if (running_crc_r != data_byte) begin
      result.status = rcftc_pkg::STATUS_BAD_CRC;
    end else begin
      result.status     = rcftc_pkg::STATUS_OK;
      result.chan_level = channel_bits_r;
      if (check_due_r) begin
        result.action = (channel_bits_r > threshold) ? rcftc_pkg::ACTION_START
                                                     : rcftc_pkg::ACTION_STOP;
      end
    end
  end

  // Next state for one transaction
  always_comb begin
    byte_count_nxt   = byte_count_r;
    running_crc_nxt  = running_crc_r;
    frame_type_nxt   = frame_type_r;
    channel_bits_nxt = channel_bits_r;
    check_due_nxt    = check_due_r;
    overlong_nxt     = overlong_r;
    if (fire) begin
      if (mode == rcftc_pkg::MODE_TICK) begin
        check_due_nxt = 1'b1;
      end else if (!last_byte) begin
        if (full) begin
          overlong_nxt = 1'b1;
        end else begin
          if (byte_count_r == IDX_W'(rcftc_pkg::TYPE_BYTE)) begin
            frame_type_nxt = data_byte;
          end
          if (byte_count_r >= IDX_W'(rcftc_pkg::TYPE_BYTE)) begin
            running_crc_nxt = rcftc_pkg::crc8_step(running_crc_r, data_byte);
          end
          channel_bits_nxt = captured_bits;
          byte_count_nxt   = byte_count_r + IDX_W'(1);
        end
      end else begin
        // End of frame: consume the pending check on a good frame, clear the rest
        if (result.action != rcftc_pkg::ACTION_NONE) begin
          check_due_nxt = 1'b0;
        end
        byte_count_nxt   = '0;
        running_crc_nxt  = '0;
        frame_type_nxt   = '0;
        channel_bits_nxt = '0;
        overlong_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      running_crc_r  <= '0;
      frame_type_r   <= '0;
      channel_bits_r <= '0;
      check_due_r    <= 1'b1;
      overlong_r     <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      running_crc_r  <= running_crc_nxt;
      frame_type_r   <= frame_type_nxt;
      channel_bits_r <= channel_bits_nxt;
      check_due_r    <= check_due_nxt;
      overlong_r     <= overlong_nxt;
    end
  end

endmodule

// ----- sim/rc_channel_frame_threshold_checker_top_tb.sv -----
// Self-checking testbench for the RC channel frame threshold checker: directed and random frames.
module rc_channel_frame_threshold_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAME_LEN_MAX  = 64;
  localparam int          CLK_PERIOD     = 10;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned MIN_LEN        = rcftc_pkg::MIN_FRAME_LEN;
  localparam int unsigned TYPE_IDX       = rcftc_pkg::TYPE_BYTE;

  logic clk = 1'b0;
  logic rst_n;
  logic                             cfg_wr_en;
  logic [rcftc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rcftc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rcftc_in_if  in_if ();
  rcftc_out_if out_if ();

  rc_channel_frame_threshold_checker_top #(
    .MAX_FRAME_LEN(FRAME_LEN_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies held by the predictor
  logic [4:0]  chan_sel;
  logic [10:0] thresh;
  logic [7:0]  exp_type;

  // Per-frame state of the predictor
  logic [6:0]  byte_idx;
  logic [7:0]  running_crc;
  logic [7:0]  frame_type;
  logic [10:0] channel_bits;
  logic        check_due;
  logic        overlong;

  rcftc_pkg::result_t pending_verdicts[$];

  int unsigned items_sent;
  int unsigned verdicts_checked;
  int unsigned ok_frames;
  int unsigned start_count;
  int unsigned stop_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Idle and stall knobs, and the long receiver hold-off
  int unsigned send_gap_pct;
  int unsigned ready_stall_pct;
  int unsigned hold_left;

  // CRC-8, poly 0xD5, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) c = c[7] ? ((c << 1) ^ rcftc_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  // Copy the bits of one byte that fall inside the selected channel
  function automatic void capture_channel_bits(input int unsigned idx, input logic [7:0] data);
    int unsigned base;
    int unsigned lo;
    int unsigned chan;
    if (idx < rcftc_pkg::CHAN_START_BYTE) return;
    // select 0 behaves as channel 1, anything above 16 as channel 16
    if (chan_sel == 5'd0) chan = 0;
    else if (chan_sel > rcftc_pkg::NUM_CHANNELS) chan = rcftc_pkg::NUM_CHANNELS - 1;
    else chan = chan_sel - 1;
    base = (idx - rcftc_pkg::CHAN_START_BYTE) * 8;
    lo   = chan * rcftc_pkg::CHAN_BITS;
    for (int b = 0; b < 8; b++) begin
      if (base + b >= lo && base + b < lo + rcftc_pkg::CHAN_BITS) begin
        channel_bits[base + b - lo] = data[b];
      end
    end
  endfunction

  // Advance the predictor by one accepted transaction; queue a verdict at a last byte
  function automatic void predict_verdict(input logic mode, input logic [7:0] data,
                                          input logic last);
    rcftc_pkg::result_t v;
    int unsigned        flen;
    if (mode == rcftc_pkg::MODE_TICK) begin
      check_due = 1'b1;
      return;
    end
    if (!last) begin
      if (byte_idx >= FRAME_LEN_MAX) begin
        overlong = 1'b1;
        return;
      end
      if (byte_idx == TYPE_IDX) frame_type = data;
      if (byte_idx >= TYPE_IDX) running_crc = crc8_update(running_crc, data);
      capture_channel_bits(byte_idx, data);
      byte_idx++;
      return;
    end
    flen = byte_idx + 1;
    // first failing check wins
    if (overlong || flen < MIN_LEN || flen > FRAME_LEN_MAX) v.status = rcftc_pkg::STATUS_BAD_LEN;
    else if (frame_type != exp_type) v.status = rcftc_pkg::STATUS_BAD_TYPE;
    else if (running_crc != data) v.status = rcftc_pkg::STATUS_BAD_CRC;
    else v.status = rcftc_pkg::STATUS_OK;
    v.action     = rcftc_pkg::ACTION_NONE;
    v.chan_level = '0;
    if (v.status == rcftc_pkg::STATUS_OK) begin
      ok_frames++;
      v.chan_level = channel_bits;
      if (check_due) begin
        check_due = 1'b0;
        v.action  = (channel_bits > thresh) ? rcftc_pkg::ACTION_START : rcftc_pkg::ACTION_STOP;
        if (v.action == rcftc_pkg::ACTION_START) start_count++;
        else stop_count++;
      end
    end
    pending_verdicts.push_back(v);
    byte_idx     = '0;
    running_crc  = '0;
    frame_type   = '0;
    channel_bits = '0;
    overlong     = 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  // Offer one transaction, with random idle cycles first, and wait for acceptance
  task automatic send_item(input logic mode, input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_if.valid     = 1'b0;
      in_if.mode      = 1'($urandom_range(1));
      in_if.data_byte = 8'($urandom_range(255));
      in_if.last_byte = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.mode      = mode;
    in_if.data_byte = data;
    in_if.last_byte = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    predict_verdict(mode, data, last);
  endtask

  // Stop offering, let every verdict arrive, then give the pipeline time to empty
  task automatic settle_block();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [rcftc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rcftc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wdata = rcftc_pkg::CFG_DATA_W'($urandom_range(2047));
    case (idx)
      rcftc_pkg::CFG_CHANNEL_SELECT: chan_sel = value[4:0];
      rcftc_pkg::CFG_THRESHOLD:      thresh   = value[10:0];
      rcftc_pkg::CFG_EXPECTED_TYPE:  exp_type = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [10:0] sel, input logic [10:0] thr,
                             input logic [10:0] typ);
    settle_block();
    write_register(rcftc_pkg::CFG_CHANNEL_SELECT, sel);
    write_register(rcftc_pkg::CFG_THRESHOLD, thr);
    write_register(rcftc_pkg::CFG_EXPECTED_TYPE, typ);
  endtask

  // Build and send one frame of len bytes; fill < 0 gives random payload.
  // A channel select switch can be made idle in mid-frame before byte switch_at.
  task automatic send_frame(input int len, input bit bad_type, input bit bad_crc,
                            input int fill = -1, input int unsigned tick_pct = 0,
                            input int switch_at = -1, input logic [4:0] switch_sel = 5'd1);
    logic [7:0] body[$];
    logic [7:0] crc;
    logic [7:0] b;
    for (int i = 0; i < len - 1; i++) begin
      if (i == TYPE_IDX) b = bad_type ? exp_type ^ (8'd1 << $urandom_range(7)) : exp_type;
      else b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      body.push_back(b);
    end
    crc = '0;
    for (int i = TYPE_IDX; i < len - 1 && i < FRAME_LEN_MAX; i++) begin
      crc = crc8_update(crc, body[i]);
    end
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) begin
      if (i == switch_at) begin
        settle_block();
        write_register(rcftc_pkg::CFG_CHANNEL_SELECT, switch_sel);
      end
      if ($urandom_range(99) < tick_pct) begin
        send_item(rcftc_pkg::MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if (i < len - 1) send_item(rcftc_pkg::MODE_BYTE, body[i], 1'b0);
      else send_item(rcftc_pkg::MODE_BYTE, crc, 1'b1);
    end
  endtask

  // Default registers, first frame compares, second one does not
  task automatic test_reset_state();
    send_frame(MIN_LEN, 1'b0, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0);
  endtask

  // Single-byte, too short, shortest, longest, one over and overlong frames
  task automatic test_frame_lengths();
    send_frame(1, 1'b0, 1'b0);
    send_frame(MIN_LEN - 1, 1'b0, 1'b0);
    send_item(rcftc_pkg::MODE_TICK, 8'h00, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0, 8'h00);
    send_item(rcftc_pkg::MODE_TICK, 8'hFF, 1'b1);
    send_frame(FRAME_LEN_MAX, 1'b0, 1'b0, 8'hFF);
    send_frame(FRAME_LEN_MAX + 1, 1'b0, 1'b0);
    send_frame(FRAME_LEN_MAX + 2, 1'b1, 1'b1);
  endtask

  // Length beats type, type beats CRC
  task automatic test_check_order();
    send_frame(MIN_LEN - 3, 1'b1, 1'b1);
    send_frame(MIN_LEN, 1'b1, 1'b1);
    send_frame(MIN_LEN, 1'b1, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b1);
  endtask

  // Ticks ignore byte fields; failed frames keep a pending comparison
  task automatic test_tick_handling();
    send_item(rcftc_pkg::MODE_TICK, 8'hFF, 1'b1);
    send_frame(MIN_LEN, 1'b0, 1'b1);
    send_frame(MIN_LEN, 1'b1, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0, -1, 30);
    send_frame(MIN_LEN, 1'b0, 1'b0);
  endtask

  // Register extremes, including out-of-range channel numbers
  task automatic test_register_extremes();
    load_config(11'd16, 11'd0, 11'd0);
    send_frame(MIN_LEN, 1'b0, 1'b0, 8'hFF);
    send_item(rcftc_pkg::MODE_TICK, 8'h5A, 1'b0);
    load_config(11'd31, 11'd2047, 11'd255);
    send_frame(MIN_LEN, 1'b0, 1'b0, 8'hFF);
    send_item(rcftc_pkg::MODE_TICK, 8'hA5, 1'b1);
    load_config(11'd0, 11'd0, 11'h7A5);
    send_frame(MIN_LEN, 1'b0, 1'b0, 8'h00);
    send_item(rcftc_pkg::MODE_TICK, 8'h00, 1'b0);
    load_config(11'h7F1, 11'd1024, 11'h716);
    send_frame(MIN_LEN + 4, 1'b0, 1'b0);
  endtask

  // Channel select changed while a frame is part way in
  task automatic test_midframe_select();
    load_config(11'd3, 11'd512, 11'd22);
    send_item(rcftc_pkg::MODE_TICK, 8'h00, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0, -1, 0, 6, 5'd1);
    send_item(rcftc_pkg::MODE_TICK, 8'h00, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0, -1, 0, 4, 5'd16);
  endtask

  // Receiver holds off while short frames pile up, then the sender drains
  task automatic test_backpressure();
    settle_block();
    hold_left = 300;
    repeat (10) send_frame(1, 1'b0, 1'b0);
    send_frame(MIN_LEN, 1'b0, 1'b0);
    repeat (10) send_frame($urandom_range(1, 3), 1'b0, 1'b0);
    settle_block();
    send_frame(MIN_LEN, 1'b0, 1'b1);
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    int unsigned kind;
    int          len;
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 76) begin
        len = ($urandom_range(3) != 0) ? MIN_LEN : $urandom_range(MIN_LEN + 1, FRAME_LEN_MAX);
        send_frame(len, $urandom_range(9) == 0, $urandom_range(9) == 0, -1, 3);
      end else if (kind < 86) begin
        send_frame($urandom_range(1, MIN_LEN - 1), 1'($urandom_range(1)),
                   1'($urandom_range(1)), -1, 3);
      end else if (kind < 92) begin
        send_frame($urandom_range(FRAME_LEN_MAX + 1, FRAME_LEN_MAX + 8), 1'b0, 1'b0, -1, 3);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(9) == 0);
        end
      end
    end
    send_gap_pct    = 0;
    ready_stall_pct = 0;
  endtask

  // Receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Compare each verdict taken with the oldest one predicted
  always @(posedge clk) begin
    rcftc_pkg::result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      verdicts_checked++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict with none pending: status %0d action %0d value %0d",
                                  out_if.status, out_if.action, out_if.chan_level));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
        if (out_if.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", out_if.action, want.action));
        if (out_if.chan_level !== want.chan_level)
          report_mismatch($sformatf("channel level %0d, want %0d",
                                    out_if.chan_level, want.chan_level));
      end
    end
  end

  always @(posedge clk) cycle_count++;

  // Timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned drain_start;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = rcftc_pkg::MODE_BYTE;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = rcftc_pkg::CFG_CHANNEL_SELECT;
    cfg_wdata       = '0;
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    hold_left       = 0;
    // predictor reset state
    chan_sel     = rcftc_pkg::CHANNEL_SELECT_RST;
    thresh       = rcftc_pkg::THRESHOLD_RST;
    exp_type     = rcftc_pkg::EXPECTED_TYPE_RST;
    byte_idx     = '0;
    running_crc  = '0;
    frame_type   = '0;
    channel_bits = '0;
    overlong     = 1'b0;
    check_due    = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_frame_lengths();
    test_check_order();
    test_tick_handling();
    test_register_extremes();
    test_midframe_select();
    test_backpressure();

    load_config(11'd1, 11'd0, 11'd0);
    test_random_traffic(0, 0, 30);
    load_config(11'd16, 11'd2047, 11'd255);
    test_random_traffic(47, 0, 30);
    load_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                11'($urandom_range(2047)));
    test_random_traffic(0, 47, 30);
    load_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                11'($urandom_range(2047)));
    test_random_traffic(38, 38, 30);

    // final drain, bounded so that a lost verdict shows as a failure
    @(negedge clk);
    in_if.valid = 1'b0;
    drain_start = cycle_count;
    while (pending_verdicts.size() != 0 && cycle_count - drain_start < DRAIN_LIMIT) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end

    $display("Run covered %0d transactions in and %0d verdicts out",
             items_sent, verdicts_checked);
    $display("(%0d good frames, %0d start, %0d stop, %0d mismatches).",
             ok_frames, start_count, stop_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
